[src/lzwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary engine package
// Shared constants, operation and status codes, and the controller states.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int DICT_DEPTH_DEF = 4096;
	localparam int MAX_STRING_DEF = 64;

	// Roots are the letters a..z and hold codes 0..25.
	localparam logic [7:0] ROOT_FIRST = 8'd97;
	localparam logic [7:0] ROOT_END   = 8'd123;
	localparam int         ROOT_COUNT = 26;

	localparam logic signed [12:0] ROOT_PREFIX = -13'sd1;

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_EXPAND = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_FULL       = 2'd2,
		STAT_UNASSIGNED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RESP,
		ST_SCAN,
		ST_WALK,
		ST_WALK_WAIT,
		ST_POP_RD,
		ST_POP_OUT
	} state_t;

endpackage

[src/lzwd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[src/lzw_dictionary_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary engine
// Dictionary of (prefix, symbol) entries over the roots a..z with find, add,
// expand and clear operations.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ stream, one item per command. Results leave on the
// m_ stream; m_tlast marks the final result of a command. Find, add and clear
// give one result; expand gives one result per symbol of the string, first
// symbol first, or one error result.
// Find scans the stored entries through one memory port, one per cycle, up to
// the last code or a hit. Add, clear and root finds go through the decode and
// response states only. Expand walks the prefix chain, a read and a push state
// per entry, then reads the symbol stack back, a read and an output state each.
// One command is worked at a time; the next item is taken once the previous
// one has handed its last result to the output register.
// Reset empties the output register and sets the dictionary back to the 26
// roots; the root symbols are constants, so no clearing pass is needed.
// When the receiver stalls, the output register holds its item and the
// controller waits for it to be taken before producing the next one.
// ----------------------------------------------------------------------------
module lzw_dictionary_engine_top #(
	parameter int DICT_DEPTH = lzwd_pkg::DICT_DEPTH_DEF,
	parameter int MAX_STRING = lzwd_pkg::MAX_STRING_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // operation[1:0], prefix_code[14:2], symbol[22:15],
	                              // code[34:23], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // result_code[11:0], out_symbol[19:12], status[21:20],
	                              // zero fill
	output logic        m_tlast
);

	import lzwd_pkg::*;

	localparam int AW  = $clog2(DICT_DEPTH);
	localparam int SW  = $clog2(MAX_STRING);
	localparam int CW  = $clog2(MAX_STRING + 1);
	localparam int XW  = 17;
	localparam int DW  = AW + 8;

	// Command registers.
	state_t              state_q, state_d;
	op_t                 op_q;
	logic signed [12:0]  prefix_q;
	logic [7:0]          symbol_q;
	logic [11:0]         code_q;

	logic [AW-1:0]       last_code_q;

	// Pending single result.
	logic [11:0]         res_code_q;
	status_t             res_status_q;

	// Scan pipeline.
	logic [AW:0]         scan_q;
	logic                rd_vld_s1;
	logic [AW-1:0]       rd_addr_s1;

	// Expansion walk and symbol stack.
	logic [AW-1:0]       cur_q;
	logic [SW-1:0]       wptr_q, pptr_q;
	logic [CW-1:0]       cnt_q, remain_q;
	logic                ovf_q;

	// Output register.
	logic                out_valid_q;
	logic [11:0]         out_code_q;
	logic [7:0]          out_sym_q;
	status_t             out_status_q;
	logic                out_last_q;

	// Memory ports.
	logic                dict_en, dict_we;
	logic [AW-1:0]       dict_addr;
	logic [DW-1:0]       dict_wdata, dict_rdata;
	logic [AW-1:0]       dict_prefix;
	logic [7:0]          dict_sym;
	logic                stack_en, stack_we;
	logic [SW-1:0]       stack_addr;
	logic [7:0]          stack_wdata, stack_rdata;

	// Control.
	logic                accept, out_free;
	logic                pfx_root, pfx_neg, pfx_big, sym_root, dict_full, code_big;
	logic                has_entries, cur_root;
	logic                go_scan, go_walk, resp_set;
	logic [11:0]         resp_code;
	status_t             resp_status;
	logic                scan_hit, scan_end, scan_issue;
	logic                push, push_final;
	logic                pop_fin;
	logic                out_load, out_last;
	logic [11:0]         out_code;
	logic [7:0]          out_sym;
	status_t             out_status;
	logic [CW-1:0]       cnt_next;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	assign dict_prefix = dict_rdata[DW-1:8];
	assign dict_sym    = dict_rdata[7:0];

	assign pfx_root    = (prefix_q == ROOT_PREFIX);
	assign pfx_neg     = prefix_q[12];
	assign pfx_big     = XW'(prefix_q[11:0]) > XW'(last_code_q);
	assign sym_root    = (symbol_q >= ROOT_FIRST) && (symbol_q < ROOT_END);
	assign dict_full   = (XW'(last_code_q) == XW'(DICT_DEPTH - 1));
	assign code_big    = XW'(code_q) > XW'(last_code_q);
	assign has_entries = (XW'(last_code_q) >= XW'(ROOT_COUNT));
	assign cur_root    = (XW'(cur_q) < XW'(ROOT_COUNT));

	assign scan_hit = rd_vld_s1 && (dict_prefix == AW'(prefix_q[11:0]))
		&& (dict_sym == symbol_q);
	assign scan_end = rd_vld_s1 && (rd_addr_s1 == last_code_q);
	assign pop_fin  = (remain_q == CW'(1));
	assign cnt_next = (cnt_q == CW'(MAX_STRING)) ? cnt_q : cnt_q + CW'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (go_scan) state_d = ST_SCAN;
				else if (go_walk) state_d = ST_WALK;
				else state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_hit || scan_end) state_d = ST_RESP;
			end
			ST_WALK: begin
				state_d = cur_root ? ST_POP_RD : ST_WALK_WAIT;
			end
			ST_WALK_WAIT: begin
				state_d = ST_WALK;
			end
			ST_POP_RD: begin
				state_d = ST_POP_OUT;
			end
			ST_POP_OUT: begin
				if (out_free) state_d = pop_fin ? ST_IDLE : ST_POP_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		go_scan     = 1'b0;
		go_walk     = 1'b0;
		resp_set    = 1'b0;
		resp_code   = '0;
		resp_status = STAT_OK;
		dict_en     = 1'b0;
		dict_we     = 1'b0;
		dict_addr   = cur_q;
		dict_wdata  = {AW'(prefix_q[11:0]), symbol_q};
		stack_en    = 1'b0;
		stack_we    = 1'b0;
		stack_addr  = pptr_q;
		stack_wdata = dict_sym;
		scan_issue  = 1'b0;
		push        = 1'b0;
		push_final  = 1'b0;
		out_load    = 1'b0;
		out_code    = res_code_q;
		out_sym     = '0;
		out_status  = res_status_q;
		out_last    = 1'b1;
		case (state_q)
			ST_DECODE: begin
				case (op_q)
					OP_FIND: begin
						if (pfx_root) begin
							resp_set = 1'b1;
							if (sym_root) resp_code = 12'(symbol_q - ROOT_FIRST);
							else resp_status = STAT_NOT_FOUND;
						end else if (pfx_neg || pfx_big || !has_entries) begin
							resp_set    = 1'b1;
							resp_status = STAT_NOT_FOUND;
						end else begin
							go_scan = 1'b1;
						end
					end
					OP_ADD: begin
						resp_set = 1'b1;
						if (pfx_neg || pfx_big) begin
							resp_status = STAT_UNASSIGNED;
						end else if (dict_full) begin
							resp_status = STAT_FULL;
						end else begin
							dict_en   = 1'b1;
							dict_we   = 1'b1;
							dict_addr = last_code_q + AW'(1);
							resp_code = 12'(last_code_q + AW'(1));
						end
					end
					OP_EXPAND: begin
						if (code_big) begin
							resp_set    = 1'b1;
							resp_status = STAT_UNASSIGNED;
						end else begin
							go_walk = 1'b1;
						end
					end
					OP_CLEAR: begin
						resp_set = 1'b1;
					end
					default: resp_set = 1'b1;
				endcase
			end
			ST_RESP: begin
				out_load = out_free;
			end
			ST_SCAN: begin
				scan_issue = (scan_q <= {1'b0, last_code_q}) && !scan_hit && !scan_end;
				dict_en    = scan_issue;
				dict_addr  = scan_q[AW-1:0];
				if (scan_hit) begin
					resp_set  = 1'b1;
					resp_code = 12'(rd_addr_s1);
				end else if (scan_end) begin
					resp_set    = 1'b1;
					resp_status = STAT_NOT_FOUND;
				end
			end
			ST_WALK: begin
				if (cur_root) begin
					push        = 1'b1;
					push_final  = 1'b1;
					stack_wdata = ROOT_FIRST + 8'(cur_q[4:0]);
				end else begin
					dict_en = 1'b1;
				end
			end
			ST_WALK_WAIT: begin
				push = 1'b1;
			end
			ST_POP_RD: begin
				stack_en = 1'b1;
			end
			ST_POP_OUT: begin
				out_load   = out_free;
				out_code   = '0;
				out_sym    = stack_rdata;
				out_status = (pop_fin && ovf_q) ? STAT_FULL : STAT_OK;
				out_last   = pop_fin;
			end
			default: ;
		endcase
		if (push) begin
			stack_en   = 1'b1;
			stack_we   = 1'b1;
			stack_addr = wptr_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_code_q <= AW'(ROOT_COUNT - 1);
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_issue;
			if (state_q == ST_DECODE && op_q == OP_CLEAR) begin
				last_code_q <= AW'(ROOT_COUNT - 1);
			end else if (dict_we) begin
				last_code_q <= last_code_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(s_tdata[1:0]);
			prefix_q <= s_tdata[14:2];
			symbol_q <= s_tdata[22:15];
			code_q   <= s_tdata[34:23];
		end
		if (resp_set) begin
			res_code_q   <= resp_code;
			res_status_q <= resp_status;
		end
		if (go_scan) begin
			scan_q <= (AW + 1)'(ROOT_COUNT);
		end else if (scan_issue) begin
			scan_q <= scan_q + (AW + 1)'(1);
		end
		rd_addr_s1 <= scan_q[AW-1:0];
		if (go_walk) begin
			cur_q  <= AW'(code_q);
			wptr_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (push) begin
			// The stack is a ring: a chain longer than it keeps the entries
			// nearest the root, which are the head of the string.
			wptr_q <= (wptr_q == SW'(MAX_STRING - 1)) ? '0 : wptr_q + SW'(1);
			cnt_q  <= cnt_next;
			ovf_q  <= ovf_q || (cnt_q == CW'(MAX_STRING));
			if (!push_final) cur_q <= dict_prefix;
		end
		if (push_final) begin
			pptr_q   <= wptr_q;
			remain_q <= cnt_next;
		end else if (out_load && state_q == ST_POP_OUT) begin
			pptr_q   <= (pptr_q == '0) ? SW'(MAX_STRING - 1) : pptr_q - SW'(1);
			remain_q <= remain_q - CW'(1);
		end
		if (out_load) begin
			out_code_q   <= out_code;
			out_sym_q    <= out_sym;
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_status_q, out_sym_q, out_code_q};
	assign m_tlast  = out_last_q;

	lzwd_ram #(
		.WIDTH(DW),
		.DEPTH(DICT_DEPTH)
	) u_dict_ram (
		.clk  (clk),
		.en   (dict_en),
		.we   (dict_we),
		.addr (dict_addr),
		.wdata(dict_wdata),
		.rdata(dict_rdata)
	);

	lzwd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_STRING)
	) u_stack_ram (
		.clk  (clk),
		.en   (stack_en),
		.we   (stack_we),
		.addr (stack_addr),
		.wdata(stack_wdata),
		.rdata(stack_rdata)
	);

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DECODE))
		else $error("accepted item did not move to decode");

	a_roots_kept: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(last_code_q) >= XW'(ROOT_COUNT - 1))
		else $error("last code dropped below the roots");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while holding an item");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_OUT) |-> (remain_q != '0))
		else $error("stack pop with nothing left");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		dict_we |-> !dict_full)
		else $error("dictionary written while full");

endmodule
